>>> rtl/core/hrbi_pkg.sv
// ----------------------------------------------------------------------------
// hrbi_pkg - shared types and constants for the heart rate block
// Widths, reset values of the configuration registers, register indexes and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hrbi_pkg;

    // Ring of recent beat intervals
    localparam int RING_DEPTH = 5;
    localparam int POS_W      = $clog2(RING_DEPTH);
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    // Field widths
    localparam int TIME_W = 32;
    localparam int IVL_W  = 16;
    localparam int BPM_W  = 8;

    // Ring sum and divider widths
    localparam int SUM_W  = IVL_W + $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(SUM_W);

    // Milliseconds in one minute
    localparam logic [SUM_W-1:0] MS_PER_MINUTE = SUM_W'(60000);

    // Register reset values
    localparam logic [IVL_W-1:0] IVL_MIN_RST  = IVL_W'(300);
    localparam logic [IVL_W-1:0] IVL_MAX_RST  = IVL_W'(1500);
    localparam logic [BPM_W-1:0] RATE_MIN_RST = BPM_W'(40);
    localparam logic [BPM_W-1:0] RATE_MAX_RST = BPM_W'(180);

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_IVL_MIN  = 2'd0;
    localparam logic [1:0] REG_IVL_MAX  = 2'd1;
    localparam logic [1:0] REG_RATE_MIN = 2'd2;
    localparam logic [1:0] REG_RATE_MAX = 2'd3;

    // Item kinds
    localparam logic CMD_BEAT  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic [IVL_W-1:0] ivl_min;
        logic [IVL_W-1:0] ivl_max;
        logic [BPM_W-1:0] rate_min;
        logic [BPM_W-1:0] rate_max;
    } cfg_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;      // latch the incoming item, clear working result
        logic clear_hist;   // empty the ring, forget the last beat
        logic beat_update;  // take interval if in window, record beat time
        logic sum_start;
        logic sum_step;
        logic div_start;
        logic div_sel_rate; // 0: sum / fill, 1: 60000 / mean
        logic mean_store;
        logic rate_store;
        logic out_load;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic item_clear;
        logic interval_ok;
        logic fill_ge2;
        logic sum_last;
        logic div_done;
        logic mean_zero;
    } dp_sts_t;

endpackage

>>> rtl/core/heart_rate_from_beat_intervals.sv
// ----------------------------------------------------------------------------
// heart_rate_from_beat_intervals - heart rate from beat-to-beat intervals
// Streams beat and clear items in, one rate result item out per input item.
// ----------------------------------------------------------------------------
// One item is processed at a time. A clear item, a first beat or a beat whose
// interval falls outside the window goes from the check straight to the
// result; a taken interval with fewer than two held also passes ST_POST
// first. Once two or more intervals are held the ring is summed one entry a
// cycle and a single serial divider, one quotient bit a cycle, forms first
// the mean interval and then, unless the mean is zero, 60000 / mean.
// The input takes the next item while a result still waits in the output
// register.
// ----------------------------------------------------------------------------
module heart_rate_from_beat_intervals (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] time_ms
    input  logic        s_axis_tuser,   // [0] cmd
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] heart_rate
    output logic [1:0]  m_axis_tuser,   // [0] rate_update, [1] interval_taken
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hrbi_pkg::*;

    cfg_t      cfg_reg;
    dp_cmd_t   cmd;
    dp_sts_t   sts;
    logic      cfg_wr;
    logic [1:0] reg_idx;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ivl_min  <= IVL_MIN_RST;
            cfg_reg.ivl_max  <= IVL_MAX_RST;
            cfg_reg.rate_min <= RATE_MIN_RST;
            cfg_reg.rate_max <= RATE_MAX_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_IVL_MIN:  cfg_reg.ivl_min  <= pwdata[IVL_W-1:0];
                REG_IVL_MAX:  cfg_reg.ivl_max  <= pwdata[IVL_W-1:0];
                REG_RATE_MIN: cfg_reg.rate_min <= pwdata[BPM_W-1:0];
                REG_RATE_MAX: cfg_reg.rate_max <= pwdata[BPM_W-1:0];
                default:      cfg_reg.ivl_min  <= cfg_reg.ivl_min;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (reg_idx)
            REG_IVL_MIN:  prdata = {{(32-IVL_W){1'b0}}, cfg_reg.ivl_min};
            REG_IVL_MAX:  prdata = {{(32-IVL_W){1'b0}}, cfg_reg.ivl_max};
            REG_RATE_MIN: prdata = {{(32-BPM_W){1'b0}}, cfg_reg.rate_min};
            REG_RATE_MAX: prdata = {{(32-BPM_W){1'b0}}, cfg_reg.rate_max};
            default:      prdata = '0;
        endcase
    end

    hrbi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hrbi_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .sts        (sts),
        .in_cmd     (s_axis_tuser),
        .in_time    (s_axis_tdata),
        .out_update (m_axis_tuser[0]),
        .out_rate   (m_axis_tdata),
        .out_taken  (m_axis_tuser[1])
    );

endmodule

>>> rtl/core/hrbi_div.sv
// ----------------------------------------------------------------------------
// hrbi_div - serial restoring divider
// One quotient bit per cycle once started; done pulses once.
// ----------------------------------------------------------------------------
module hrbi_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hrbi_pkg::SUM_W-1:0]  dividend,
    input  logic [hrbi_pkg::IVL_W-1:0]  divisor,
    output logic [hrbi_pkg::SUM_W-1:0]  quotient,
    output logic                        done
);
    import hrbi_pkg::*;

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [IVL_W-1:0] rem_reg, rem_next;
    logic [IVL_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [IVL_W:0]   trial;
    logic             ge;

    // One restoring step
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? IVL_W'(trial - {1'b0, dvs_reg}) : trial[IVL_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> rtl/core/hrbi_dp.sv
// ----------------------------------------------------------------------------
// hrbi_dp - datapath of the heart rate block
// Beat history, interval ring, serial ring sum, shared divider, rate check
// and the output register.
// ----------------------------------------------------------------------------
module hrbi_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hrbi_pkg::cfg_t              cfg,
    input  hrbi_pkg::dp_cmd_t           cmd,
    output hrbi_pkg::dp_sts_t           sts,
    input  logic                        in_cmd,
    input  logic [hrbi_pkg::TIME_W-1:0] in_time,
    output logic                        out_update,
    output logic [hrbi_pkg::BPM_W-1:0]  out_rate,
    output logic                        out_taken
);
    import hrbi_pkg::*;

    // Item and history
    logic              item_cmd_reg;
    logic [TIME_W-1:0] item_time_reg;
    logic [TIME_W-1:0] last_reg;
    logic              has_prev_reg;
    logic [IVL_W-1:0]  ring_reg [RING_DEPTH];
    logic [POS_W-1:0]  pos_reg;
    logic [FILL_W-1:0] fill_reg;

    // Arithmetic
    logic [SUM_W-1:0]  sum_reg;
    logic [POS_W-1:0]  idx_reg;
    logic [IVL_W-1:0]  mean_reg;

    // Working and output results
    logic              upd_reg, taken_reg;
    logic [BPM_W-1:0]  rate_reg;
    logic              out_upd_reg, out_taken_reg;
    logic [BPM_W-1:0]  out_rate_reg;

    logic [TIME_W-1:0] rr;
    logic              ivl_ok;
    logic [SUM_W-1:0]  div_dividend;
    logic [IVL_W-1:0]  div_divisor;
    logic [SUM_W-1:0]  div_quo;
    logic              div_done;
    logic [IVL_W-1:0]  rate_full;

    // Interval from last beat and window check
    assign rr     = item_time_reg - last_reg;
    assign ivl_ok = has_prev_reg
                 && (rr >= {{(TIME_W-IVL_W){1'b0}}, cfg.ivl_min})
                 && (rr <= {{(TIME_W-IVL_W){1'b0}}, cfg.ivl_max});

    // Shared divider: mean interval, then rate
    assign div_dividend = cmd.div_sel_rate ? MS_PER_MINUTE : sum_reg;
    assign div_divisor  = cmd.div_sel_rate ? mean_reg
                                           : {{(IVL_W-FILL_W){1'b0}}, fill_reg};

    hrbi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign rate_full = div_quo[IVL_W-1:0];

    // Beat history and ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= '0;
            has_prev_reg <= 1'b0;
            pos_reg      <= '0;
            fill_reg     <= '0;
            for (int k = 0; k < RING_DEPTH; k++)
            begin
                ring_reg[k] <= '0;
            end
        end
        else if (cmd.clear_hist)
        begin
            last_reg     <= '0;
            has_prev_reg <= 1'b0;
            pos_reg      <= '0;
            fill_reg     <= '0;
            for (int k = 0; k < RING_DEPTH; k++)
            begin
                ring_reg[k] <= '0;
            end
        end
        else if (cmd.beat_update)
        begin
            last_reg     <= item_time_reg;
            has_prev_reg <= 1'b1;
            if (ivl_ok)
            begin
                ring_reg[pos_reg] <= rr[IVL_W-1:0];
                pos_reg <= (pos_reg == POS_W'(RING_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                if (fill_reg != FILL_W'(RING_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    // Item capture, sum, mean and working result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_cmd_reg  <= in_cmd;
            item_time_reg <= in_time;
            upd_reg       <= 1'b0;
            taken_reg     <= 1'b0;
            rate_reg      <= '0;
        end
        if (cmd.beat_update && ivl_ok)
        begin
            taken_reg <= 1'b1;
        end
        if (cmd.sum_start)
        begin
            sum_reg <= '0;
            idx_reg <= '0;
        end
        else if (cmd.sum_step)
        begin
            sum_reg <= sum_reg + {{(SUM_W-IVL_W){1'b0}}, ring_reg[idx_reg]};
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.mean_store)
        begin
            mean_reg <= div_quo[IVL_W-1:0];
        end
        if (cmd.rate_store)
        begin
            if ((rate_full >= {{(IVL_W-BPM_W){1'b0}}, cfg.rate_min})
             && (rate_full <= {{(IVL_W-BPM_W){1'b0}}, cfg.rate_max}))
            begin
                upd_reg  <= 1'b1;
                rate_reg <= rate_full[BPM_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_upd_reg   <= upd_reg;
            out_rate_reg  <= rate_reg;
            out_taken_reg <= taken_reg;
        end
    end

    assign out_update = out_upd_reg;
    assign out_rate   = out_rate_reg;
    assign out_taken  = out_taken_reg;

    // Status
    assign sts.item_clear  = (item_cmd_reg == CMD_CLEAR);
    assign sts.interval_ok = ivl_ok;
    assign sts.fill_ge2    = (fill_reg >= FILL_W'(2));
    assign sts.sum_last    = (idx_reg == POS_W'(RING_DEPTH - 1));
    assign sts.div_done    = div_done;
    assign sts.mean_zero   = (mean_reg == '0);

endmodule

>>> rtl/core/hrbi_ctrl.sv
// ----------------------------------------------------------------------------
// hrbi_ctrl - controller of the heart rate block
// Sequences one item at a time through check and, when needed, ring sum and
// the two divisions, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module hrbi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  hrbi_pkg::dp_sts_t   sts,
    output hrbi_pkg::dp_cmd_t   cmd
);
    import hrbi_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CHECK     = 4'd1;
    localparam logic [3:0] ST_POST      = 4'd2;
    localparam logic [3:0] ST_SUM       = 4'd3;
    localparam logic [3:0] ST_MEAN_GO   = 4'd4;
    localparam logic [3:0] ST_MEAN_WAIT = 4'd5;
    localparam logic [3:0] ST_RATE_GO   = 4'd6;
    localparam logic [3:0] ST_RATE_WAIT = 4'd7;
    localparam logic [3:0] ST_FINISH    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       ovld_reg, ovld_next;
    logic       out_free;

    assign out_free  = !ovld_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovld_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ovld_next  = ovld_reg;
        if (ovld_reg && out_ready)
        begin
            ovld_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.item_clear)
                begin
                    cmd.clear_hist = 1'b1;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    cmd.beat_update = 1'b1;
                    state_next      = sts.interval_ok ? ST_POST : ST_FINISH;
                end
            end
            ST_POST:
            begin
                if (sts.fill_ge2)
                begin
                    cmd.sum_start = 1'b1;
                    state_next    = ST_SUM;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_last)
                begin
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.mean_store = 1'b1;
                    state_next     = ST_RATE_GO;
                end
            end
            ST_RATE_GO:
            begin
                if (sts.mean_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start    = 1'b1;
                    cmd.div_sel_rate = 1'b1;
                    state_next       = ST_RATE_WAIT;
                end
            end
            ST_RATE_WAIT:
            begin
                cmd.div_sel_rate = 1'b1;
                if (sts.div_done)
                begin
                    cmd.rate_store = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to be free
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    ovld_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

endmodule
